// ===== design/tasr_pkg.sv =====
// shared types and constants for the tensor axis sum-reduce block
// no dependencies
package tasr_pkg;

    localparam int MAX_RANK     = 4;
    localparam int NUM_DIMS     = 4;
    localparam int RESULT_DEPTH = 4096;
    localparam int DIM_LIMIT    = 4096;

    localparam int ADDR_W  = $clog2(RESULT_DEPTH);
    localparam int ENT_W   = $clog2(RESULT_DEPTH + 1);
    localparam int DIM_W   = 13;
    localparam int POS_W   = 12;
    localparam int RANK_W  = 3;
    localparam int AXIS_W  = 2;
    localparam int VAL_W   = 64;
    localparam int RIDX_W  = 12;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 72;

    localparam logic CMD_READ = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TENSOR_RANK   = 3'd0,
        REG_SUM_AXIS      = 3'd1,
        REG_DIM0_SIZE     = 3'd2,
        REG_DIM1_SIZE     = 3'd3,
        REG_DIM2_SIZE     = 3'd4,
        REG_DIM3_SIZE     = 3'd5,
        REG_WIDE_ELEMENTS = 3'd6
    } cfg_reg_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_INCOMPLETE = 2'd1,
        STAT_RANGE      = 2'd2,
        STAT_BAD_CONFIG = 2'd3
    } read_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_ELEM_RD,
        ST_ELEM_WR,
        ST_READ_RD,
        ST_READ_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic              in_ready;
        logic              cap_in;
        logic              calc_step;
        logic              calc_fin;
        logic [AXIS_W-1:0] calc_dim;
        logic              elem_rd;
        logic              elem_wr;
        logic              read_rd;
        logic              ld_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_cmd;
        logic cfg_hit;
        logic cfg_ok;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== design/tensor_axis_sum_reduce_top.sv =====
// Sums a row-major integer tensor of rank one to four along one axis. An element word passes
// through accept, accumulator read and write-back, skipping write-back under an invalid
// configuration; a read word passes through accept and memory read, then waits for the output
// register to drain: the single-port accumulator memory and its read-modify-write set this.
// Every write to a defined register restarts the tensor and runs an entry-count pass, one
// dimension per cycle through one multiplier, during which no word is accepted. The accumulator
// store has no clearing pass; reads report ok only once the whole tensor has been written.
// depends on tasr_pkg, tasr_ctrl, tasr_datapath
module tensor_axis_sum_reduce_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tasr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tasr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tasr_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // element_value, read_index
    input  logic                               s_axis_tuser,  // cmd
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [tasr_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // sum_value, read_status
);
    import tasr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tasr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    tasr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_data  (m_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    assign s_axis_tready = cmd.in_ready;

endmodule

// ===== design/tasr_ctrl.sv =====
// controller state machine: sequences entry-count pass, element update and reads
// depends on tasr_pkg
module tasr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  tasr_pkg::dp_status_t  status,
    output tasr_pkg::ctrl_cmd_t   cmd
);
    import tasr_pkg::*;

    ctrl_state_t       state_reg, state_next;
    logic [AXIS_W-1:0] step_reg, step_next;
    logic              accept;

    localparam logic [AXIS_W-1:0] LAST_STEP = AXIS_W'(NUM_DIMS - 1);

    assign accept = (state_reg == ST_IDLE) && in_valid && !status.cfg_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        if (status.cfg_hit)
        begin
            state_next = ST_CALC;
            step_next  = '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_next = (status.in_cmd == CMD_READ) ? ST_READ_RD : ST_ELEM_RD;
                    end
                end
                ST_CALC:
                begin
                    step_next = step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_ELEM_RD:
                begin
                    state_next = status.cfg_ok ? ST_ELEM_WR : ST_IDLE;
                end
                ST_ELEM_WR:
                begin
                    state_next = ST_IDLE;
                end
                ST_READ_RD:
                begin
                    state_next = ST_READ_OUT;
                end
                ST_READ_OUT:
                begin
                    if (!status.out_busy)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        cmd.calc_dim = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = !status.cfg_hit;
                cmd.cap_in   = accept;
            end
            ST_CALC:
            begin
                cmd.calc_step = !status.cfg_hit;
                cmd.calc_fin  = !status.cfg_hit && (step_reg == LAST_STEP);
            end
            ST_ELEM_RD:
            begin
                cmd.elem_rd = status.cfg_ok;
            end
            ST_ELEM_WR:
            begin
                cmd.elem_wr = 1'b1;
            end
            ST_READ_RD:
            begin
                cmd.read_rd = 1'b1;
            end
            ST_READ_OUT:
            begin
                cmd.ld_out = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/tasr_datapath.sv =====
// datapath: configuration registers, position tracking, accumulator memory, output word
// depends on tasr_pkg
module tasr_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tasr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tasr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [tasr_pkg::IN_DATA_W-1:0]     in_data,
    input  logic                               in_user,
    output logic [tasr_pkg::OUT_DATA_W-1:0]    out_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    input  tasr_pkg::ctrl_cmd_t                cmd,
    output tasr_pkg::dp_status_t               status
);
    import tasr_pkg::*;

    // configuration
    logic [RANK_W-1:0] rank_reg;
    logic [AXIS_W-1:0] axis_reg;
    logic [DIM_W-1:0]  dim_reg [NUM_DIMS];
    logic              wide_reg;
    logic              cfg_hit;

    // entry count pass
    logic [ENT_W-1:0]  prod_reg, entries_reg, prod_new;
    logic              ovf_reg, ovf_new, valid_reg, basic_ok, calc_use;
    logic [ENT_W+DIM_W-1:0] prod_mul;

    // position tracking
    logic [POS_W-1:0]  pos_reg [NUM_DIMS];
    logic [POS_W-1:0]  pos_adv [NUM_DIMS];
    logic [DIM_W-1:0]  pos_inc [NUM_DIMS];
    logic [NUM_DIMS-1:0] wrap, cin;
    logic              done, carry, at_axis, past_axis;
    logic              complete_reg;
    logic [ADDR_W-1:0] slot_reg, base_reg, slot_inc;

    // item and memory
    logic [VAL_W-1:0]  elem_reg, rdata_reg, sum_full, sum_store, rd_value;
    logic [RIDX_W-1:0] ridx_reg;
    logic [VAL_W-1:0]  mem [RESULT_DEPTH];
    logic [ADDR_W-1:0] rd_addr;
    logic              first;

    // output word
    logic [VAL_W-1:0]  out_value_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic              out_valid_reg;
    read_status_t      rd_status;

    assign cfg_hit = cfg_we && (cfg_index <= REG_WIDE_ELEMENTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= RANK_W'(2);
            axis_reg <= '0;
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                dim_reg[d] <= DIM_W'(1);
            end
            wide_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TENSOR_RANK:   rank_reg   <= cfg_wdata[RANK_W-1:0];
                REG_SUM_AXIS:      axis_reg   <= cfg_wdata[AXIS_W-1:0];
                REG_DIM0_SIZE:     dim_reg[0] <= cfg_wdata[DIM_W-1:0];
                REG_DIM1_SIZE:     dim_reg[1] <= cfg_wdata[DIM_W-1:0];
                REG_DIM2_SIZE:     dim_reg[2] <= cfg_wdata[DIM_W-1:0];
                REG_DIM3_SIZE:     dim_reg[3] <= cfg_wdata[DIM_W-1:0];
                REG_WIDE_ELEMENTS: wide_reg   <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // range checks that need no product
    always_comb
    begin
        basic_ok = (rank_reg >= RANK_W'(1)) && (rank_reg <= RANK_W'(NUM_DIMS))
                   && (rank_reg <= RANK_W'(MAX_RANK))
                   && ({1'b0, axis_reg} < rank_reg);
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            if (RANK_W'(d) < rank_reg)
            begin
                if (dim_reg[d] < DIM_W'(1) || dim_reg[d] > DIM_W'(DIM_LIMIT))
                begin
                    basic_ok = 1'b0;
                end
            end
        end
    end

    // one dimension of the entry count per step
    assign calc_use = ({1'b0, cmd.calc_dim} < rank_reg) && (cmd.calc_dim != axis_reg);
    assign prod_mul = prod_reg * dim_reg[cmd.calc_dim];
    assign ovf_new  = ovf_reg || (calc_use && (prod_mul > (ENT_W+DIM_W)'(RESULT_DEPTH)));
    assign prod_new = (calc_use && !ovf_new) ? prod_mul[ENT_W-1:0] : prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg    <= ENT_W'(1);
            ovf_reg     <= 1'b0;
            valid_reg   <= 1'b1;
            entries_reg <= ENT_W'(1);
        end
        else if (cfg_hit)
        begin
            prod_reg <= ENT_W'(1);
            ovf_reg  <= 1'b0;
        end
        else if (cmd.calc_step)
        begin
            prod_reg <= prod_new;
            ovf_reg  <= ovf_new;
            if (cmd.calc_fin)
            begin
                valid_reg   <= basic_ok && !ovf_new;
                entries_reg <= prod_new;
            end
        end
    end

    // carry through the used dimensions, innermost first
    always_comb
    begin
        carry = 1'b1;
        cin   = '0;
        for (int d = NUM_DIMS - 1; d >= 0; d--)
        begin
            pos_inc[d] = {1'b0, pos_reg[d]} + DIM_W'(1);
            wrap[d]    = pos_inc[d] >= dim_reg[d];
            pos_adv[d] = pos_reg[d];
            if (RANK_W'(d) < rank_reg)
            begin
                cin[d] = carry;
                if (carry)
                begin
                    pos_adv[d] = wrap[d] ? '0 : pos_inc[d][POS_W-1:0];
                end
                carry = carry & wrap[d];
            end
        end
        done      = carry;
        at_axis   = cin[axis_reg] && !wrap[axis_reg];
        past_axis = cin[axis_reg] && wrap[axis_reg] && !done;
        slot_inc  = slot_reg + 1'b1;
    end

    assign first     = (pos_reg[axis_reg] == '0);
    assign sum_full  = first ? elem_reg : rdata_reg + elem_reg;
    assign sum_store = wide_reg ? sum_full : {32'b0, sum_full[31:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                pos_reg[d] <= '0;
            end
            complete_reg <= 1'b0;
            slot_reg     <= '0;
            base_reg     <= '0;
        end
        else if (cfg_hit)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                pos_reg[d] <= '0;
            end
            complete_reg <= 1'b0;
            slot_reg     <= '0;
            base_reg     <= '0;
        end
        else if (cmd.elem_wr)
        begin
            pos_reg      <= pos_adv;
            complete_reg <= done;
            priority if (done)
            begin
                slot_reg <= '0;
                base_reg <= '0;
            end
            else if (at_axis)
            begin
                slot_reg <= base_reg;
            end
            else if (past_axis)
            begin
                slot_reg <= slot_inc;
                base_reg <= slot_inc;
            end
            else
            begin
                slot_reg <= slot_inc;
            end
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            elem_reg <= in_data[VAL_W-1:0];
            ridx_reg <= in_data[VAL_W+RIDX_W-1:VAL_W];
        end
    end

    // accumulator memory
    assign rd_addr = cmd.read_rd ? ridx_reg[ADDR_W-1:0] : slot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.elem_rd || cmd.read_rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.elem_wr)
        begin
            mem[slot_reg] <= sum_store;
        end
    end

    // read answer
    always_comb
    begin
        rd_value = wide_reg ? rdata_reg : {{32{rdata_reg[31]}}, rdata_reg[31:0]};
        priority if (!valid_reg)
        begin
            rd_status = STAT_BAD_CONFIG;
        end
        else if ({1'b0, ridx_reg} >= entries_reg)
        begin
            rd_status = STAT_RANGE;
        end
        else if (!complete_reg)
        begin
            rd_status = STAT_INCOMPLETE;
        end
        else
        begin
            rd_status = STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.ld_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_out)
        begin
            out_value_reg  <= (rd_status == STAT_OK) ? rd_value : '0;
            out_status_reg <= rd_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(OUT_DATA_W - VAL_W - STAT_W){1'b0}}, out_status_reg, out_value_reg};

    assign status.in_cmd   = in_user;
    assign status.cfg_hit  = cfg_hit;
    assign status.cfg_ok   = valid_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

    a_wr_needs_valid_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.elem_wr |-> valid_reg)
        else $error("accumulator written under invalid configuration");

    a_complete_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
        complete_reg |-> (pos_reg[0] == '0 && pos_reg[1] == '0 && pos_reg[2] == '0
                          && pos_reg[3] == '0 && slot_reg == '0))
        else $error("finished tensor left position counters off origin");

    a_load_free_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_out |-> !(out_valid_reg && !out_ready))
        else $error("output word overwritten before it was taken");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.elem_wr |-> ({1'b0, slot_reg} < entries_reg))
        else $error("accumulator slot beyond result entry count");

endmodule

// ===== dv/tensor_axis_sum_reduce_top_test.sv =====
// self-checking bench for tensor_axis_sum_reduce_top: streams elements and reads under many
// tensor shapes and keeps a shadow of the accumulator store to predict every reply word
// depends on tasr_pkg and tensor_axis_sum_reduce_top
module tensor_axis_sum_reduce_top_test;
    import tasr_pkg::*;

    localparam logic                 CMD_ELEMENT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 3'd7;
    localparam int                   SETTLE_CYCLES = 12;
    localparam int                   QUIET_LIMIT   = 2000;
    localparam int                   RANDOM_WORDS  = 1200;
    localparam int                   LONG_EXTENT   = 256;

    typedef struct {
        logic              cmd;
        logic [VAL_W-1:0]  elem;
        logic [RIDX_W-1:0] ridx;
    } word_t;

    typedef struct {
        logic [VAL_W-1:0] sum;
        read_status_t     status;
    } reply_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // element_value, read_index
    logic                  s_axis_tuser  = 1'b0; // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // sum_value, read_status

    // shadow of the registers and state
    logic [RANK_W-1:0]     cur_rank = 3'd2;
    logic [AXIS_W-1:0]     cur_axis = 2'd0;
    logic [DIM_W-1:0]      cur_dim [NUM_DIMS] = '{default: 13'd1};
    logic                  cur_wide = 1'b0;
    int unsigned           pos [NUM_DIMS] = '{default: 0};
    logic                  tensor_done = 1'b0;
    logic [VAL_W-1:0]      acc_mem [RESULT_DEPTH];

    word_t       word_q [$];
    reply_t      reply_q [$];
    word_t       bus_word;
    int unsigned words_open   = 0;
    int unsigned words_taken  = 0;
    int unsigned stim_words   = 0;
    int unsigned replies_seen = 0;
    int unsigned full_reads   = 0;
    int unsigned reg_writes   = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_gap     = 0;
    int unsigned stall_left   = 0;
    bit          no_idle      = 1'b0;

    tensor_axis_sum_reduce_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    function automatic bit shape_ok(output int unsigned entries);
        int unsigned n;
        n = 1;
        entries = 0;
        if (cur_rank < 1 || cur_rank > NUM_DIMS || cur_rank > MAX_RANK)
            return 1'b0;
        if (cur_axis >= cur_rank)
            return 1'b0;
        for (int d = 0; d < cur_rank; d++)
        begin
            if (cur_dim[d] < 1 || cur_dim[d] > DIM_LIMIT)
                return 1'b0;
            if (d != cur_axis)
            begin
                n = n * cur_dim[d];
                if (n > RESULT_DEPTH)
                    return 1'b0;
            end
        end
        entries = n;
        return 1'b1;
    endfunction

    function automatic void fold_word(input word_t w);
        int unsigned      entries;
        int unsigned      slot;
        bit               ok;
        bit               carry;
        logic [VAL_W-1:0] s;
        reply_t           r;
        ok = shape_ok(entries);
        if (w.cmd == CMD_ELEMENT)
        begin
            if (!ok)
                return;
            tensor_done = 1'b0;
            slot = 0;
            for (int d = 0; d < cur_rank; d++)
                if (d != cur_axis)
                    slot = slot * cur_dim[d] + pos[d];
            s = (pos[cur_axis] == 0) ? w.elem : acc_mem[slot] + w.elem;
            if (!cur_wide)
                s[VAL_W-1:32] = '0;
            acc_mem[slot] = s;
            carry = 1'b1;
            for (int d = NUM_DIMS - 1; d >= 0; d--)
            begin
                if (carry && d < cur_rank)
                begin
                    pos[d]++;
                    if (pos[d] < cur_dim[d])
                        carry = 1'b0;
                    else
                        pos[d] = 0;
                end
            end
            if (carry)
                tensor_done = 1'b1;
        end
        else
        begin
            r.sum = '0;
            if (!ok)
                r.status = STAT_BAD_CONFIG;
            else if (w.ridx >= entries)
                r.status = STAT_RANGE;
            else if (!tensor_done)
                r.status = STAT_INCOMPLETE;
            else
            begin
                r.status = STAT_OK;
                r.sum = acc_mem[w.ridx];
                if (!cur_wide)
                    r.sum = {{32{r.sum[31]}}, r.sum[31:0]};
                full_reads++;
            end
            reply_q.insert(reply_q.size(), r);
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_extent();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return $urandom_range(1, 3);
        if (r < 18)
            return $urandom_range(4, 6);
        return $urandom_range(7, 16);
    endfunction

    function automatic int unsigned pick_index(input int unsigned entries);
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, entries - 1);
        return $urandom_range(0, RESULT_DEPTH - 1);
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 64'h7FFF_FFFF_FFFF_FFFF;
            1:       return 64'h8000_0000_0000_0000;
            2:       return {$urandom, 32'h7FFF_FFFF};
            3:       return {$urandom, 32'h8000_0000};
            4:       return 64'(int'($urandom_range(0, 32)) - 16);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
        $display("reply %0d %s: got %h, want %h", replies_seen, what, got, want);
        mismatches++;
    endtask

    task automatic push_elem(input logic [VAL_W-1:0] v);
        word_t       w;
        int unsigned n;
        w.cmd  = CMD_ELEMENT;
        w.elem = v;
        w.ridx = RIDX_W'($urandom);
        word_q.insert(word_q.size(), w);
        words_open++;
        if (shape_ok(n))
            stim_words++;
    endtask

    task automatic push_read(input int unsigned idx);
        word_t w;
        w.cmd  = CMD_READ;
        w.elem = {$urandom, $urandom};
        w.ridx = RIDX_W'(idx);
        word_q.insert(word_q.size(), w);
        words_open++;
        stim_words++;
    endtask

    // wait until every word is taken and answered, then let the block go idle
    task automatic settle();
        while (words_open != 0 || reply_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
        logic [CFG_DATA_W-1:0] keep_mask;
        logic [CFG_DATA_W-1:0] data;
        case (idx)
            REG_TENSOR_RANK:   keep_mask = 13'h0007;
            REG_SUM_AXIS:      keep_mask = 13'h0003;
            REG_WIDE_ELEMENTS: keep_mask = 13'h0001;
            default:           keep_mask = '1;
        endcase
        data = CFG_DATA_W'(v);
        // junk above a narrow register must be dropped
        if ($urandom_range(0, 1) == 1)
            data = (data & keep_mask) | (CFG_DATA_W'($urandom) & ~keep_mask);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        reg_writes++;
        case (idx)
            REG_TENSOR_RANK:   cur_rank   = data[RANK_W-1:0];
            REG_SUM_AXIS:      cur_axis   = data[AXIS_W-1:0];
            REG_DIM0_SIZE:     cur_dim[0] = data;
            REG_DIM1_SIZE:     cur_dim[1] = data;
            REG_DIM2_SIZE:     cur_dim[2] = data;
            REG_DIM3_SIZE:     cur_dim[3] = data;
            REG_WIDE_ELEMENTS: cur_wide   = data[0];
            default:           ;
        endcase
        if (idx != REG_UNUSED)
        begin
            pos = '{default: 0};
            tensor_done = 1'b0;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_shape(input int unsigned rank, input int unsigned axis,
                              input int unsigned d0, input int unsigned d1,
                              input int unsigned d2, input int unsigned d3,
                              input int unsigned wide);
        set_reg(REG_TENSOR_RANK, rank);
        set_reg(REG_SUM_AXIS, axis);
        set_reg(REG_DIM0_SIZE, d0);
        set_reg(REG_DIM1_SIZE, d1);
        set_reg(REG_DIM2_SIZE, d2);
        set_reg(REG_DIM3_SIZE, d3);
        set_reg(REG_WIDE_ELEMENTS, wide);
    endtask

    // input side driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            hold_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                fold_word(bus_word);
                words_taken++;
                words_open--;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (hold_gap > 0)
                begin
                    hold_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (word_q.size() > 0)
                begin
                    bus_word = word_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(IN_DATA_W - RIDX_W - VAL_W){1'b0}},
                                      bus_word.ridx, bus_word.elem};
                    s_axis_tuser  <= bus_word.cmd;
                    hold_gap = pick_gap();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side monitor
    always @(posedge clk or negedge rst_n)
    begin : reply_check
        reply_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                replies_seen++;
                if (reply_q.size() == 0)
                    flag_mismatch("reply with none pending", m_axis_tdata[VAL_W-1:0], '0);
                else
                begin
                    want = reply_q.pop_front();
                    if (m_axis_tdata[VAL_W-1:0] !== want.sum)
                        flag_mismatch("sum_value", m_axis_tdata[VAL_W-1:0], want.sum);
                    if (m_axis_tdata[VAL_W+STAT_W-1:VAL_W] !== want.status)
                        flag_mismatch("read_status",
                                      VAL_W'(m_axis_tdata[VAL_W+STAT_W-1:VAL_W]),
                                      VAL_W'(want.status));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tensor_axis_sum_reduce_top: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int unsigned rank;
        int unsigned axis;
        int unsigned total;
        int unsigned entries;
        int unsigned cut;
        int unsigned dims [NUM_DIMS];
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // reset shape: two dimensions of extent one, narrow sums
        push_read(0);
        push_read(1);
        push_read(RESULT_DEPTH - 1);
        push_elem(64'h8000_0000_8000_0000);
        push_read(0);
        push_elem(64'hFFFF_FFFF_7FFF_FFFF);
        push_read(0);
        settle();

        // rank one, wide sums wrapping through zero
        load_shape(1, 0, 3, 1, 1, 1, 1);
        push_elem(64'h7FFF_FFFF_FFFF_FFFF);
        push_elem(64'h7FFF_FFFF_FFFF_FFFF);
        push_elem(64'd2);
        push_read(0);
        push_read(1);
        push_elem(64'd5);
        push_read(0);
        settle();

        // rank four on the last axis, narrow wrap, unused index must not restart
        load_shape(4, 3, 2, 1, 1, 2, 0);
        push_elem(64'hFFFF_FFFF_8000_0000);
        push_elem(64'h0000_0000_8000_0000);
        push_elem(64'h0000_0000_7FFF_FFFF);
        settle();
        set_reg(REG_UNUSED, $urandom);
        push_elem(64'd1);
        push_read(0);
        push_read(1);
        push_read(2);
        settle();

        // largest extent on the last dimension, full result range
        load_shape(4, 2, 1, 1, 2, DIM_LIMIT, 0);
        push_elem(rand_value());
        push_read(RESULT_DEPTH - 1);
        settle();

        load_shape(7, 0, 1, 1, 1, 1, 0);
        push_elem(64'd3);
        push_read(0);
        settle();
        set_reg(REG_TENSOR_RANK, 2);
        set_reg(REG_SUM_AXIS, 3);
        push_read(0);
        settle();

        // one long tensor that fills all LONG_EXTENT of its result entries
        load_shape(2, 1, LONG_EXTENT, 1, 1, 1, $urandom_range(0, 1));
        repeat (LONG_EXTENT) push_elem(rand_value());
        push_read(LONG_EXTENT - 1);
        push_read(0);
        repeat (6) push_read($urandom_range(0, RESULT_DEPTH - 1));

        while (stim_words < RANDOM_WORDS)
        begin
            settle();
            rank  = $urandom_range(1, NUM_DIMS);
            axis  = $urandom_range(0, rank - 1);
            total = 1;
            foreach (dims[d])
            begin
                dims[d] = pick_extent();
                if (d < rank)
                    total = total * dims[d];
            end
            if (total > 256)
            begin
                total = 1;
                foreach (dims[d])
                begin
                    dims[d] = $urandom_range(1, 3);
                    if (d < rank)
                        total = total * dims[d];
                end
            end
            // now and then a shape the block must refuse
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: rank = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 7);
                    1:
                    begin
                        rank = $urandom_range(1, 3);
                        axis = $urandom_range(rank, 3);
                    end
                    2: dims[$urandom_range(0, rank - 1)] = 0;
                    3: dims[$urandom_range(0, rank - 1)] = $urandom_range(DIM_LIMIT + 1, 8191);
                    default:
                    begin
                        rank    = 3;
                        axis    = 2;
                        dims[0] = $urandom_range(65, DIM_LIMIT);
                        dims[1] = $urandom_range(64, DIM_LIMIT);
                    end
                endcase
            end
            load_shape(rank, axis, dims[0], dims[1], dims[2], dims[3], $urandom_range(0, 1));
            no_idle = ($urandom_range(0, 4) == 0);
            if (!shape_ok(entries))
            begin
                repeat ($urandom_range(3, 8))
                    if ($urandom_range(0, 1) == 1)
                        push_elem(rand_value());
                    else
                        push_read($urandom_range(0, RESULT_DEPTH - 1));
            end
            else
            begin
                // part of a tensor, then a write while idle
                if ($urandom_range(0, 5) == 0)
                begin
                    cut = $urandom_range(1, total);
                    repeat (cut) push_elem(rand_value());
                    push_read(pick_index(entries));
                    settle();
                    if ($urandom_range(0, 1) == 1)
                        set_reg(REG_WIDE_ELEMENTS, cur_wide);
                    else
                        set_reg(REG_UNUSED, $urandom);
                end
                repeat ($urandom_range(1, 3))
                begin
                    for (int e = 0; e < total; e++)
                    begin
                        push_elem(rand_value());
                        if ($urandom_range(0, 19) == 0)
                            push_read(pick_index(entries));
                        if ($urandom_range(0, 79) == 0)
                            break;
                        if (stim_words >= RANDOM_WORDS)
                            break;
                    end
                    repeat ($urandom_range(1, 5)) push_read(pick_index(entries));
                end
            end
        end
        no_idle = 1'b0;
        settle();

        $display("ran %0d words through %0d register writes, %0d replies checked",
                 words_taken, reg_writes, replies_seen);
        $display("%0d reads returned a finished sum", full_reads);
        if (mismatches == 0)
            $display("tensor_axis_sum_reduce_top: match");
        else
            $display("tensor_axis_sum_reduce_top: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tasr_pkg.sv
design/tasr_ctrl.sv
design/tasr_datapath.sv
design/tensor_axis_sum_reduce_top.sv
dv/tensor_axis_sum_reduce_top_test.sv
